@@ src/bdlb_pkg.sv @@
`default_nettype none

package bdlb_pkg;

   // Register indexes on the CSR port
   localparam logic [2:0] REG_DEBOUNCE_TICKS   = 3'd0;
   localparam logic [2:0] REG_SHORT_PRESS_MAX  = 3'd1;
   localparam logic [2:0] REG_LONG_PRESS_TICKS = 3'd2;
   localparam logic [2:0] REG_SLOW_HALF_PERIOD = 3'd3;
   localparam logic [2:0] REG_FAST_HALF_PERIOD = 3'd4;

   // Register reset values
   localparam logic [15:0] DEBOUNCE_TICKS_RST   = 16'd15;
   localparam logic [15:0] SHORT_PRESS_MAX_RST  = 16'd1000;
   localparam logic [15:0] LONG_PRESS_TICKS_RST = 16'd3000;
   localparam logic [15:0] SLOW_HALF_PERIOD_RST = 16'd500;
   localparam logic [15:0] FAST_HALF_PERIOD_RST = 16'd100;

   // LED mode codes
   localparam logic [1:0] MODE_OFF  = 2'd0;
   localparam logic [1:0] MODE_SLOW = 2'd1;
   localparam logic [1:0] MODE_FAST = 2'd2;

   localparam logic [15:0] CNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [15:0] debounce_ticks;
      logic [15:0] short_press_max;
      logic [15:0] long_press_ticks;
      logic [15:0] slow_half_period;
      logic [15:0] fast_half_period;
   } cfg_type;

   typedef struct packed {
      logic        filtered_sample;
      logic        committed_level;
      logic        previous_level;
      logic        settling;
      logic [15:0] settle_count;
      logic [15:0] press_count;
      logic        hold_armed;
      logic [1:0]  mode;
      logic        led1;
      logic        led2;
      logic [15:0] slow_count;
      logic [15:0] fast_count;
   } state_type;

   typedef struct packed {
      logic       led1_level;
      logic       led2_level;
      logic [1:0] led_mode;
      logic       stable_level;
      logic       press_event;
      logic       release_event;
      logic       short_press_event;
      logic       long_press_event;
   } result_type;

endpackage

`default_nettype wire

@@ src/bdlb_tick.sv @@
`default_nettype none

// Next-state and result logic for one millisecond tick.
module bdlb_tick (
   input  wire bdlb_pkg::cfg_type    cfg,
   input  wire bdlb_pkg::state_type  cur,
   input  wire                       sample,
   output bdlb_pkg::state_type       nxt,
   output bdlb_pkg::result_type      res
);

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == bdlb_pkg::CNT_MAX) ? v : v + 16'd1;
   endfunction

   logic [15:0] settle_inc;
   logic [15:0] press_inc;
   logic [15:0] slow_inc;
   logic [15:0] fast_inc;
   logic        changed;
   logic        settling_pre;
   logic [15:0] settle_pre;
   logic        commit;
   logic        level;
   logic        level_edge;
   logic        press_ev;
   logic        release_ev;
   logic        short_ev;
   logic        long_ev;
   logic        hold_pre;
   logic [15:0] press_pre;
   logic [1:0]  mode_next;

   always_comb begin
      settle_inc = sat_inc(cur.settle_count);
      press_inc  = sat_inc(cur.press_count);
      slow_inc   = sat_inc(cur.slow_count);
      fast_inc   = sat_inc(cur.fast_count);

      // debounce: restart the settle count on any raw change
      changed      = sample != cur.filtered_sample;
      settling_pre = changed | cur.settling;
      settle_pre   = changed ? 16'd0 : settle_inc;
      commit       = settling_pre && (settle_pre >= cfg.debounce_ticks);
      level        = commit ? sample : cur.committed_level;

      // press and release
      level_edge = level != cur.previous_level;
      press_ev   = level_edge & level;
      release_ev = level_edge & ~level;
      short_ev   = release_ev && (press_inc <= cfg.short_press_max);
      hold_pre   = press_ev | (cur.hold_armed & ~release_ev);
      press_pre  = press_ev ? 16'd0 : press_inc;

      case (cur.mode)
         bdlb_pkg::MODE_OFF:  mode_next = press_ev ? bdlb_pkg::MODE_SLOW : cur.mode;
         bdlb_pkg::MODE_SLOW: mode_next = press_ev ? bdlb_pkg::MODE_FAST : cur.mode;
         default:             mode_next = press_ev ? bdlb_pkg::MODE_OFF  : cur.mode;
      endcase

      // long press fires once per press
      long_ev = hold_pre && (press_pre >= cfg.long_press_ticks);

      nxt                 = cur;
      nxt.filtered_sample = sample;
      nxt.committed_level = level;
      nxt.previous_level  = level;
      nxt.settling        = settling_pre & ~commit;
      nxt.settle_count    = settle_pre;
      nxt.press_count     = press_pre;
      nxt.hold_armed      = hold_pre & ~long_ev;
      nxt.mode            = mode_next;
      nxt.slow_count      = slow_inc;
      nxt.fast_count      = fast_inc;

      case (mode_next)
         bdlb_pkg::MODE_SLOW: begin
            if (slow_inc >= cfg.slow_half_period) begin
               nxt.led1       = ~cur.led1;
               nxt.slow_count = 16'd0;
            end
         end
         bdlb_pkg::MODE_FAST: begin
            if (fast_inc >= cfg.fast_half_period) begin
               nxt.led2       = ~cur.led2;
               nxt.fast_count = 16'd0;
            end
         end
         default: begin
            nxt.led1 = 1'b1;
            nxt.led2 = 1'b0;
         end
      endcase

      res.led1_level        = nxt.led1;
      res.led2_level        = nxt.led2;
      res.led_mode          = mode_next;
      res.stable_level      = level;
      res.press_event       = press_ev;
      res.release_event     = release_ev;
      res.short_press_event = short_ev;
      res.long_press_event  = long_ev;
   end

endmodule

`default_nettype wire

@@ src/button_debounce_led_mode_blinker.sv @@
`default_nettype none

// Channel | Direction | Handshake          | Word
// req     | in        | req_valid/stall    | button_sample (one ms tick)
// rsp     | out       | rsp_valid/stall    | LED levels, mode, level, events
// csr     | in        | csr_valid/ready    | csr_index, csr_wdata (16 bit)
//
// Each tick word is held in the input register; the tick logic then
// computes the next state and the result word into the output register; each
// result is taken from there, one word per cycle while rsp_stall stays low.
// req_stall follows rsp_stall only while both registers hold a word.
// Synchronous reset clears all state and loads the register defaults.
// CSR writes are always ready and apply to ticks processed after the write edge.
module button_debounce_led_mode_blinker (
   input  wire        clock,
   input  wire        reset,

   input  wire        req_valid,
   output logic       req_stall,
   input  wire        req_button_sample,

   output logic       rsp_valid,
   input  wire        rsp_stall,
   output logic       rsp_led1_level,
   output logic       rsp_led2_level,
   output logic [1:0] rsp_led_mode,
   output logic       rsp_stable_level,
   output logic       rsp_press_event,
   output logic       rsp_release_event,
   output logic       rsp_short_press_event,
   output logic       rsp_long_press_event,

   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire [2:0]  csr_index,
   input  wire [15:0] csr_wdata
);

   bdlb_pkg::cfg_type    cfg_ff;
   bdlb_pkg::state_type  state_ff;
   bdlb_pkg::state_type  state_in;
   bdlb_pkg::result_type res_in;
   bdlb_pkg::result_type res_ff;

   logic in_valid_ff;
   logic in_sample_ff;
   logic out_valid_ff;
   logic out_free;
   logic advance;

   // Output register can take a word when empty or drained this cycle
   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign advance   = in_valid_ff & out_free;
   assign req_stall = in_valid_ff & ~out_free;
   assign csr_ready = 1'b1;

   bdlb_tick u_tick (
      .cfg    (cfg_ff),
      .cur    (state_ff),
      .sample (in_sample_ff),
      .nxt    (state_in),
      .res    (res_in)
   );

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= bdlb_pkg::DEBOUNCE_TICKS_RST;
         cfg_ff.short_press_max  <= bdlb_pkg::SHORT_PRESS_MAX_RST;
         cfg_ff.long_press_ticks <= bdlb_pkg::LONG_PRESS_TICKS_RST;
         cfg_ff.slow_half_period <= bdlb_pkg::SLOW_HALF_PERIOD_RST;
         cfg_ff.fast_half_period <= bdlb_pkg::FAST_HALF_PERIOD_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bdlb_pkg::REG_DEBOUNCE_TICKS:   cfg_ff.debounce_ticks   <= csr_wdata;
            bdlb_pkg::REG_SHORT_PRESS_MAX:  cfg_ff.short_press_max  <= csr_wdata;
            bdlb_pkg::REG_LONG_PRESS_TICKS: cfg_ff.long_press_ticks <= csr_wdata;
            bdlb_pkg::REG_SLOW_HALF_PERIOD: cfg_ff.slow_half_period <= csr_wdata;
            bdlb_pkg::REG_FAST_HALF_PERIOD: cfg_ff.fast_half_period <= csr_wdata;
            default: ;  // drop writes past the register list
         endcase
      end
   end

   // Input stage: hold the word while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_sample_ff <= req_button_sample;
      end
   end

   // Block state advances once per processed tick; all-zero state is mode off
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_led1_level        = res_ff.led1_level;
   assign rsp_led2_level        = res_ff.led2_level;
   assign rsp_led_mode          = res_ff.led_mode;
   assign rsp_stable_level      = res_ff.stable_level;
   assign rsp_press_event       = res_ff.press_event;
   assign rsp_release_event     = res_ff.release_event;
   assign rsp_short_press_event = res_ff.short_press_event;
   assign rsp_long_press_event  = res_ff.long_press_event;

endmodule

`default_nettype wire

@@ tb/sv/bdlb_tick_checker.sv @@
`timescale 1ns / 100ps

// Watches the tick, result and CSR channels of the debouncer, predicts each
// result word from its own copy of the state and compares in order.
module bdlb_tick_checker
   import bdlb_pkg::*;
(
   input  wire        clock,
   input  wire        reset,
   input  wire        req_valid,
   input  wire        req_stall,
   input  wire        req_button_sample,
   input  wire        rsp_valid,
   input  wire        rsp_stall,
   input  wire        rsp_led1_level,
   input  wire        rsp_led2_level,
   input  wire [1:0]  rsp_led_mode,
   input  wire        rsp_stable_level,
   input  wire        rsp_press_event,
   input  wire        rsp_release_event,
   input  wire        rsp_short_press_event,
   input  wire        rsp_long_press_event,
   input  wire        csr_valid,
   input  wire        csr_ready,
   input  wire [2:0]  csr_index,
   input  wire [15:0] csr_wdata,
   output int         mismatches,
   output int         pending,
   output int         words_checked,
   output int         presses_seen,
   output int         shorts_seen,
   output int         longs_seen
);

   cfg_type     cfg;
   logic        filt, lvl, prev_lvl, settling, armed, led1, led2;
   logic [15:0] settle_cnt, press_cnt, slow_cnt, fast_cnt;
   logic [1:0]  mode;

   result_type  tick_outcomes[$];

   function automatic logic [15:0] bump(input logic [15:0] v);
      return (v == CNT_MAX) ? v : v + 16'd1;
   endfunction

   // One millisecond tick of the debouncer, press timer and blinker.
   function automatic result_type debounce_tick(input logic sample);
      result_type r;
      r = '0;
      settle_cnt = bump(settle_cnt);
      press_cnt  = bump(press_cnt);
      slow_cnt   = bump(slow_cnt);
      fast_cnt   = bump(fast_cnt);

      if (sample != filt) begin
         filt       = sample;
         settling   = 1'b1;
         settle_cnt = '0;
      end
      if (settling && settle_cnt >= cfg.debounce_ticks) begin
         lvl      = filt;
         settling = 1'b0;
      end

      if (lvl != prev_lvl) begin
         if (!lvl) begin
            r.release_event     = 1'b1;
            r.short_press_event = (press_cnt <= cfg.short_press_max);
            armed               = 1'b0;
         end else begin
            r.press_event = 1'b1;
            armed         = 1'b1;
            case (mode)
               MODE_OFF:  mode = MODE_SLOW;
               MODE_SLOW: mode = MODE_FAST;
               default:   mode = MODE_OFF;
            endcase
            press_cnt = '0;
         end
         prev_lvl = lvl;
      end

      if (armed && press_cnt >= cfg.long_press_ticks) begin
         r.long_press_event = 1'b1;
         armed              = 1'b0;
      end

      if (mode == MODE_SLOW) begin
         if (slow_cnt >= cfg.slow_half_period) begin
            led1     = ~led1;
            slow_cnt = '0;
         end
      end else if (mode == MODE_FAST) begin
         if (fast_cnt >= cfg.fast_half_period) begin
            led2     = ~led2;
            fast_cnt = '0;
         end
      end else begin
         led1 = 1'b1;
         led2 = 1'b0;
      end

      r.led1_level   = led1;
      r.led2_level   = led2;
      r.led_mode     = mode;
      r.stable_level = lvl;
      return r;
   endfunction

   always @(posedge clock) begin
      result_type got, want;
      if (reset) begin
         cfg.debounce_ticks   = DEBOUNCE_TICKS_RST;
         cfg.short_press_max  = SHORT_PRESS_MAX_RST;
         cfg.long_press_ticks = LONG_PRESS_TICKS_RST;
         cfg.slow_half_period = SLOW_HALF_PERIOD_RST;
         cfg.fast_half_period = FAST_HALF_PERIOD_RST;
         {filt, lvl, prev_lvl, settling, armed, led1, led2} = '0;
         {settle_cnt, press_cnt, slow_cnt, fast_cnt} = '0;
         mode = MODE_OFF;
         tick_outcomes.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DEBOUNCE_TICKS:   cfg.debounce_ticks   = csr_wdata;
               REG_SHORT_PRESS_MAX:  cfg.short_press_max  = csr_wdata;
               REG_LONG_PRESS_TICKS: cfg.long_press_ticks = csr_wdata;
               REG_SLOW_HALF_PERIOD: cfg.slow_half_period = csr_wdata;
               REG_FAST_HALF_PERIOD: cfg.fast_half_period = csr_wdata;
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            got = {rsp_led1_level, rsp_led2_level, rsp_led_mode, rsp_stable_level,
                   rsp_press_event, rsp_release_event, rsp_short_press_event,
                   rsp_long_press_event};
            words_checked++;
            presses_seen += int'(got.press_event);
            shorts_seen  += int'(got.short_press_event);
            longs_seen   += int'(got.long_press_event);
            if (tick_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t: unexpected result word %b", $realtime, got);
            end else begin
               want = tick_outcomes.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%t: word %0d led1/led2/mode/level/press/rel/short/long",
                               " exp %b/%b/%0d/%b/%b/%b/%b/%b got %b/%b/%0d/%b/%b/%b/%b/%b"},
                              $realtime, words_checked,
                              want.led1_level, want.led2_level, want.led_mode,
                              want.stable_level, want.press_event, want.release_event,
                              want.short_press_event, want.long_press_event,
                              got.led1_level, got.led2_level, got.led_mode,
                              got.stable_level, got.press_event, got.release_event,
                              got.short_press_event, got.long_press_event);
               end
            end
         end

         if (req_valid && !req_stall)
            tick_outcomes.push_back(debounce_tick(req_button_sample));
      end
      pending = tick_outcomes.size();
   end

   initial begin
      mismatches    = 0;
      pending       = 0;
      words_checked = 0;
      presses_seen  = 0;
      shorts_seen   = 0;
      longs_seen    = 0;
   end

endmodule

@@ tb/sv/button_debounce_led_mode_blinker_tb.sv @@
`timescale 1ns / 100ps

module button_debounce_led_mode_blinker_tb;
   import bdlb_pkg::*;

   // Pacing of the two channels: which side idles how often
   localparam int PACE_SEND_LIGHT = 0;  // sender 13 %, receiver 57 %
   localparam int PACE_SEND_HEAVY = 1;  // sender 57 %, receiver 13 %
   localparam int PACE_NONE       = 2;  // neither side idles

   // Generous: well above the length of the slowest run
   localparam int CYCLE_LIMIT = 600000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid, req_stall, req_button_sample;
   logic        rsp_valid, rsp_stall;
   logic        rsp_led1_level, rsp_led2_level, rsp_stable_level;
   logic        rsp_press_event, rsp_release_event;
   logic        rsp_short_press_event, rsp_long_press_event;
   logic [1:0]  rsp_led_mode;
   logic        csr_valid, csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_wdata;

   int mismatches, pending, words_checked, presses_seen, shorts_seen, longs_seen;
   int pace;
   int ticks_sent;
   int cycle_count;
   bit held_off;
   int deb_t, short_t, long_t;   // current settings, used to shape press lengths

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   button_debounce_led_mode_blinker uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_button_sample     (req_button_sample),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_led1_level        (rsp_led1_level),
      .rsp_led2_level        (rsp_led2_level),
      .rsp_led_mode          (rsp_led_mode),
      .rsp_stable_level      (rsp_stable_level),
      .rsp_press_event       (rsp_press_event),
      .rsp_release_event     (rsp_release_event),
      .rsp_short_press_event (rsp_short_press_event),
      .rsp_long_press_event  (rsp_long_press_event),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   bdlb_tick_checker checker_i (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_button_sample     (req_button_sample),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_led1_level        (rsp_led1_level),
      .rsp_led2_level        (rsp_led2_level),
      .rsp_led_mode          (rsp_led_mode),
      .rsp_stable_level      (rsp_stable_level),
      .rsp_press_event       (rsp_press_event),
      .rsp_release_event     (rsp_release_event),
      .rsp_short_press_event (rsp_short_press_event),
      .rsp_long_press_event  (rsp_long_press_event),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .mismatches            (mismatches),
      .pending               (pending),
      .words_checked         (words_checked),
      .presses_seen          (presses_seen),
      .shorts_seen           (shorts_seen),
      .longs_seen            (longs_seen)
   );

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still expected",
                  cycle_count, pending);
         $display("button_debounce_led_mode_blinker_tb NOT OK");
         $finish;
      end
   end

   // Result side: random stalls per the current pacing, plus one long
   // hold-off early on so the two pipeline stages fill and back-pressure
   // reaches req_stall while the sender keeps offering ticks.
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (!held_off && ticks_sent >= 150) begin
            held_off = 1'b1;
            rsp_stall <= 1'b1;
            repeat (60) @(negedge clock);
         end
         case (pace)
            PACE_SEND_LIGHT: rsp_stall <= ($urandom_range(99) < 57);
            PACE_SEND_HEAVY: rsp_stall <= ($urandom_range(99) < 13);
            default:         rsp_stall <= 1'b0;
         endcase
      end
   end

   // Offer one tick word, with random idle cycles ahead of it, and hold it
   // until the block takes it. Returns just after the accepting edge.
   task automatic send_tick(input bit level);
      int gap, pct;
      gap = 0;
      pct = (pace == PACE_SEND_LIGHT) ? 13 : (pace == PACE_SEND_HEAVY) ? 57 : 0;
      while ($urandom_range(99) < pct)
         gap++;
      @(negedge clock);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_button_sample <= level;
      do
         @(posedge clock);
      while (req_stall);
      ticks_sent++;
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drain the pipe: drop valid, wait for every expected word, then let the
   // pipeline settle before touching the registers.
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_timing(input int deb, input int shrt, input int lng,
                             input int slow, input int fast);
      drain();
      csr_write(REG_DEBOUNCE_TICKS, deb[15:0]);
      csr_write(REG_SHORT_PRESS_MAX, shrt[15:0]);
      csr_write(REG_LONG_PRESS_TICKS, lng[15:0]);
      csr_write(REG_SLOW_HALF_PERIOD, slow[15:0]);
      csr_write(REG_FAST_HALF_PERIOD, fast[15:0]);
      deb_t   = deb;
      short_t = shrt;
      long_t  = lng;
   endtask

   // Random length in [lo, hi], clipped so default-sized settings stay quick.
   function automatic int span(input int lo, input int hi);
      return $urandom_range((hi > 200) ? 200 : hi, (lo > 200) ? 200 : lo);
   endfunction

   // One press: contact bounce, a hold, release bounce, then rest.
   // Kind 0 is a glitch that may never commit, kind 1 aims at a short
   // press, kind 2 at a press held toward or past the long limit.
   task automatic press_burst(input int kind);
      int hold, rest, nb;
      case (kind)
         0:       hold = span(1, deb_t);
         1:       hold = span(deb_t + 1, deb_t + short_t + 1);
         default: hold = span(deb_t + short_t, deb_t + long_t + 3);
      endcase
      rest = span(1, deb_t + 6);
      nb = $urandom_range(3);
      for (int i = 0; i < nb; i++)
         send_tick(~i[0]);
      repeat (hold) send_tick(1'b1);
      nb = $urandom_range(3);
      for (int i = 0; i < nb; i++)
         send_tick(i[0]);
      repeat (rest) send_tick(1'b0);
   endtask

   task automatic random_run(input int count);
      int start, r, nb;
      start = ticks_sent;
      while (ticks_sent - start < count) begin
         r = $urandom_range(9);
         if (r < 8) begin
            press_burst($urandom_range(2));
         end else begin
            nb = $urandom_range(8, 1);
            repeat (nb) send_tick(1'($urandom_range(1)));
         end
      end
   endtask

   // Zero debounce commits every change at once: press and release on
   // alternate ticks, a hold past the long limit, mode wrapping back to off.
   localparam bit [0:19] DIRECTED_TICKS = 20'b0101111110101010100_0;

   initial begin
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_button_sample = 1'b0;
      csr_valid         = 1'b0;
      csr_index         = REG_DEBOUNCE_TICKS;
      csr_wdata         = '0;
      pace              = PACE_SEND_LIGHT;
      ticks_sent        = 0;
      cycle_count       = 0;
      held_off          = 1'b0;
      deb_t             = int'(DEBOUNCE_TICKS_RST);
      short_t           = int'(SHORT_PRESS_MAX_RST);
      long_t            = int'(LONG_PRESS_TICKS_RST);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset defaults first, untouched.
      random_run(300);

      // Directed: the zero debounce and slow registers make their compares true at once.
      set_timing(0, 3, 5, 0, 1);
      for (int i = 0; i < 20; i++)
         send_tick(DIRECTED_TICKS[i]);

      set_timing(2, 8, 20, 3, 2);
      random_run(300);

      pace = PACE_SEND_HEAVY;
      set_timing(1, 1, 1, 1, 1);
      random_run(250);
      // Long limit below the short limit: the long event fires mid-press.
      set_timing(5, 30, 12, 7, 13);
      random_run(300);

      pace = PACE_NONE;
      set_timing(3, 65535, 65535, 65535, 65535);
      random_run(300);

      // Largest debounce: nothing new ever commits.
      set_timing(65535, 4, 6, 2, 3);
      random_run(100);
      set_timing(9, 15, 40, 4, 6);
      random_run(400);

      drain();
      $display("covered %0d tick words over eight register settings, zero to full scale;",
               words_checked);
      $display("saw %0d presses, %0d short and %0d long press events, %0d mismatches",
               presses_seen, shorts_seen, longs_seen, mismatches);
      if (mismatches == 0 && pending == 0)
         $display("button_debounce_led_mode_blinker_tb OK");
      else
         $display("button_debounce_led_mode_blinker_tb NOT OK");
      $finish;
   end

endmodule
